>>> src/hhft_pkg.sv
// Shared types and constants for the HTTP header field tagger.
`default_nettype none
package hhft_pkg;

    localparam int unsigned NUM_NAMES = 5;

    // One classified input byte as it travels from the front end to the parser.
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] lower;
        logic       msg_start;
        logic       is_nul;
        logic       is_lf;
        logic       is_cr;
        logic       is_space;
        logic       is_colon;
    } t_item;

    typedef logic [3:0] t_tag;

    localparam t_tag TAG_DELIM     = 4'd0;
    localparam t_tag TAG_METHOD    = 4'd1;
    localparam t_tag TAG_RESP_VER  = 4'd4;
    localparam t_tag TAG_NAME      = 4'd7;
    localparam t_tag TAG_VALUE0    = 4'd8;
    localparam t_tag TAG_OTHER     = 4'd13;
    localparam t_tag TAG_AFTER_END = 4'd14;

    localparam logic [1:0] MODE_REQUEST = 2'd0;
    localparam logic [1:0] MODE_STATUS  = 2'd1;

    localparam logic [2:0] KIND_OTHER = 3'd5;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // Known header names, lowercase, padded with NUL.
    localparam logic [7:0] KNOWN_NAMES [0:4][0:15] = '{
        '{"a","c","c","e","p","t",8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
          8'h00,8'h00,8'h00,8'h00},
        '{"f","r","o","m",8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
          8'h00,8'h00,8'h00,8'h00},
        '{"h","o","s","t",8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
          8'h00,8'h00,8'h00,8'h00},
        '{"c","o","n","t","e","n","t","-","t","y","p","e",
          8'h00,8'h00,8'h00,8'h00},
        '{"c","o","n","t","e","n","t","-","l","e","n","g","t","h",
          8'h00,8'h00}
    };
    localparam logic [3:0] KNOWN_LENS [0:4] = '{4'd6, 4'd4, 4'd4, 4'd12, 4'd14};

endpackage
`default_nettype wire

>>> src/http_header_field_tagger_core.sv
// Top level of the HTTP header field tagger.
//
// Input channel (i_in_valid / o_in_ready) carries one byte of an HTTP message
// head with a message-start flag. Output channel (o_out_valid / i_out_ready)
// returns the same byte with its field tag and an end-of-head flag, one result
// per byte and in order. The write channel (i_cfg_valid / o_cfg_ready) sets the
// start line mode: request line, status line or start line ignored; it is
// always ready and should be written only while no byte is in flight.
// The classified byte is written into a two-entry queue at its input transfer;
// the parser pops it from the queue and registers the result in its output
// register, from which the result transfers. Throughput is one byte per cycle
// while the receiver is ready. When the receiver stalls the output register
// holds, the queue fills and o_in_ready drops once two bytes wait.
// Reset clears the parser state and selects request-line mode; bytes are
// accepted from the first cycle after reset.
`default_nettype none
module http_header_field_tagger_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_start_line_mode,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_message_start,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_byte_out,
    output logic [3:0]      o_field_tag,
    output logic            o_end_of_head
);
    import hhft_pkg::*;

    t_item front_item;
    t_item q_item;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;
    logic  push;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !q_full;
    assign push        = i_in_valid && !q_full;

    hhft_front u_front (
        .i_data_byte     (i_data_byte),
        .i_message_start (i_message_start),
        .o_item          (front_item)
    );

    hhft_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    hhft_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_mode    (i_start_line_mode),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_byte_out    (o_byte_out),
        .o_field_tag   (o_field_tag),
        .o_end_of_head (o_end_of_head)
    );

endmodule
`default_nettype wire

>>> src/hhft_front.sv
// Front end: classifies each accepted byte and lowercases it for name matching.
`default_nettype none
module hhft_front (
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_message_start,
    output hhft_pkg::t_item    o_item
);
    import hhft_pkg::*;

    logic is_upper;

    always_comb begin
        is_upper          = (i_data_byte >= 8'h41) && (i_data_byte <= 8'h5A);
        o_item.data       = i_data_byte;
        o_item.lower      = is_upper ? (i_data_byte | 8'h20) : i_data_byte;
        o_item.msg_start  = i_message_start;
        o_item.is_nul     = (i_data_byte == CH_NUL);
        o_item.is_lf      = (i_data_byte == CH_LF);
        o_item.is_cr      = (i_data_byte == CH_CR);
        o_item.is_space   = (i_data_byte == CH_SPACE);
        o_item.is_colon   = (i_data_byte == CH_COLON);
    end

endmodule
`default_nettype wire

>>> src/hhft_queue.sv
// Two-entry queue between the classifying front end and the parser.
`default_nettype none
module hhft_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire hhft_pkg::t_item i_item,
    output logic               o_full,
    output logic               o_valid,
    output hhft_pkg::t_item    o_item,
    input  wire logic          i_pop
);
    import hhft_pkg::*;

    t_item      r_mem [0:1];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wr_ptr] <= i_item;
                r_wr_ptr        <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2) else $error("queue count out of range");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || i_pop) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("pop from empty queue");

endmodule
`default_nettype wire

>>> src/hhft_back.sv
// Parser back end: tracks the head's phase, matches names and registers the result.
`default_nettype none
module hhft_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    input  wire logic [1:0]    i_cfg_mode,
    input  wire logic          i_q_valid,
    input  wire hhft_pkg::t_item i_q_item,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [7:0]         o_byte_out,
    output logic [3:0]         o_field_tag,
    output logic               o_end_of_head
);
    import hhft_pkg::*;

    typedef enum logic [2:0] {
        PH_F1, PH_F2, PH_F3, PH_NAME, PH_SKIP, PH_VALUE, PH_DONE
    } t_phase;

    t_phase     r_phase, n_phase, ph_e;
    logic [3:0] r_pos, n_pos, pos_e;
    logic [4:0] r_flags, n_flags, flags_e, keep;
    logic [2:0] r_kind, n_kind, kind_e, match_kind;
    logic       r_blank, n_blank, blank_e;
    logic [1:0] r_mode;
    logic       r_o_valid;
    logic [7:0] r_byte;
    t_tag       r_tag, n_tag;
    logic       r_end, n_end;
    logic       in_header;

    function automatic t_tag start_tag(input logic [1:0] mode, input logic [1:0] field);
        t_tag tag;
        case (mode)
            MODE_REQUEST: tag = TAG_METHOD + {2'b00, field};
            MODE_STATUS:  tag = TAG_RESP_VER + {2'b00, field};
            default:      tag = TAG_OTHER;
        endcase
        return tag;
    endfunction

    assign o_q_pop       = i_q_valid && (!r_o_valid || i_out_ready);
    assign o_out_valid   = r_o_valid;
    assign o_byte_out    = r_byte;
    assign o_field_tag   = r_tag;
    assign o_end_of_head = r_end;

    always_comb begin
        // A message start clears the parser before this byte is handled.
        ph_e    = i_q_item.msg_start ? PH_F1 : r_phase;
        pos_e   = i_q_item.msg_start ? 4'd0 : r_pos;
        flags_e = i_q_item.msg_start ? 5'h1F : r_flags;
        kind_e  = i_q_item.msg_start ? KIND_OTHER : r_kind;
        blank_e = i_q_item.msg_start ? 1'b1 : r_blank;

        for (int k = 0; k < NUM_NAMES; k++) begin
            keep[k] = (pos_e < KNOWN_LENS[k]) && (KNOWN_NAMES[k][pos_e] == i_q_item.lower);
        end
        match_kind = KIND_OTHER;
        for (int k = NUM_NAMES - 1; k >= 0; k--) begin
            if (flags_e[k] && (KNOWN_LENS[k] == pos_e)) begin
                match_kind = 3'(k);
            end
        end

        in_header = (ph_e == PH_NAME) || (ph_e == PH_SKIP) || (ph_e == PH_VALUE);

        n_phase = ph_e;
        n_pos   = pos_e;
        n_flags = flags_e;
        n_kind  = kind_e;
        n_blank = blank_e;
        n_tag   = TAG_DELIM;
        n_end   = 1'b0;

        if (ph_e == PH_DONE) begin
            n_tag = TAG_AFTER_END;
        end else if (i_q_item.is_nul) begin
            n_end   = 1'b1;
            n_phase = PH_DONE;
        end else if (i_q_item.is_lf) begin
            if (in_header && blank_e) begin
                n_end   = 1'b1;
                n_phase = PH_DONE;
            end else begin
                n_phase = PH_NAME;
                n_pos   = 4'd0;
                n_flags = 5'h1F;
                n_kind  = KIND_OTHER;
                n_blank = 1'b1;
            end
        end else if (i_q_item.is_cr && in_header && blank_e) begin
            n_tag = TAG_DELIM;
        end else begin
            n_blank = 1'b0;
            case (ph_e)
                PH_F1: begin
                    if (i_q_item.is_space) n_phase = PH_F2;
                    else n_tag = start_tag(r_mode, 2'd0);
                end
                PH_F2: begin
                    if (i_q_item.is_space) n_phase = PH_F3;
                    else n_tag = start_tag(r_mode, 2'd1);
                end
                PH_F3: begin
                    n_tag = start_tag(r_mode, 2'd2);
                end
                PH_NAME: begin
                    if (i_q_item.is_colon) begin
                        n_kind  = match_kind;
                        n_phase = PH_SKIP;
                    end else begin
                        n_flags = flags_e & keep;
                        if (pos_e != 4'd15) n_pos = pos_e + 4'd1;
                        n_tag = TAG_NAME;
                    end
                end
                PH_SKIP: begin
                    n_phase = PH_VALUE;
                end
                default: begin
                    n_tag = (kind_e < KIND_OTHER) ? (TAG_VALUE0 + {1'b0, kind_e}) : TAG_OTHER;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_F1;
            r_pos     <= 4'd0;
            r_flags   <= 5'h1F;
            r_kind    <= KIND_OTHER;
            r_blank   <= 1'b1;
            r_mode    <= MODE_REQUEST;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_mode;
            end
            if (o_q_pop) begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_flags <= n_flags;
                r_kind  <= n_kind;
                r_blank <= n_blank;
                r_byte  <= i_q_item.data;
                r_tag   <= n_tag;
                r_end   <= n_end;
            end
            r_o_valid <= o_q_pop || (r_o_valid && !i_out_ready);
        end
    end

    a_end_is_delim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_end |-> r_tag == TAG_DELIM) else $error("end byte not a delimiter");
    a_end_sets_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_end |-> r_phase == PH_DONE) else $error("end without done phase");
    a_tag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> r_tag <= TAG_AFTER_END) else $error("tag out of range");
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kind <= KIND_OTHER) else $error("header kind out of range");

endmodule
`default_nettype wire
